// ----- design/qrrs_pkg.sv -----
// qrrs_pkg: shared widths, status codes and sideband types for the
// quadratic real root solver pipeline. No dependencies.
`default_nettype none
package qrrs_pkg;
  localparam int QW   = 32;   // Q16.16 word
  localparam int FRAC = 16;   // fraction bits
  localparam int DW   = 68;   // discriminant / sqrt remainder width
  localparam int RW   = 34;   // square root width, one stage per bit
  localparam int NUMW = 36;   // signed numerator -b +/- sqrt(d)
  localparam int NW   = 51;   // dividend magnitude |num| << FRAC
  localparam int MW   = 33;   // divisor magnitude |2a|

  typedef logic [1:0] status_t;
  localparam status_t ST_NONE  = 2'd0;
  localparam status_t ST_ONE   = 2'd1;
  localparam status_t ST_TWO   = 2'd2;
  localparam status_t ST_AZERO = 2'd3;

  // sideband that rides with an item through discriminant and sqrt
  typedef struct packed {
    status_t            st;
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
  } side_t;

  // sideband that rides through a divider
  typedef struct packed {
    status_t st;
    logic    q_neg;
  } tag_t;
endpackage
`default_nettype wire

// ----- design/qrrs_disc.sv -----
// qrrs_disc: two-stage discriminant d = b*b - 4*a*c and classification.
// Depends on qrrs_pkg.
`default_nettype none
module qrrs_disc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic signed [qrrs_pkg::QW-1:0] a,
  input  wire logic signed [qrrs_pkg::QW-1:0] b,
  input  wire logic signed [qrrs_pkg::QW-1:0] c,
  output logic                               out_vld,
  output qrrs_pkg::side_t                    out_side,
  output logic [qrrs_pkg::DW-1:0]            out_d
);
  logic                vld1;
  logic signed [63:0]  bb;
  logic signed [63:0]  ac;
  logic signed [qrrs_pkg::QW-1:0] a1;
  logic signed [qrrs_pkg::QW-1:0] b1;
  logic signed [qrrs_pkg::DW-1:0] dsgn;
  qrrs_pkg::status_t   st;

  // stage 1: the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb <= 64'(b * b);
      ac <= 64'(a * c);
      a1 <= a;
      b1 <= b;
    end
  end

  // stage 2: exact discriminant and its sign class
  assign dsgn = qrrs_pkg::DW'(bb) - (qrrs_pkg::DW'(ac) <<< 2);

  always_comb begin
    if (a1 == '0) begin
      st = qrrs_pkg::ST_AZERO;
    end else if (dsgn[qrrs_pkg::DW-1]) begin
      st = qrrs_pkg::ST_NONE;
    end else if (dsgn == '0) begin
      st = qrrs_pkg::ST_ONE;
    end else begin
      st = qrrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side.st <= st;
      out_side.a  <= a1;
      out_side.b  <= b1;
      out_d       <= dsgn[qrrs_pkg::DW-1] ? '0 : dsgn;
    end
  end
endmodule
`default_nettype wire

// ----- design/qrrs_sqrt.sv -----
// qrrs_sqrt: floor square root, one result bit per register stage.
// Depends on qrrs_pkg.
`default_nettype none
module qrrs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire qrrs_pkg::side_t            in_side,
  input  wire logic [qrrs_pkg::DW-1:0]    in_d,
  output logic                            out_vld,
  output qrrs_pkg::side_t                 out_side,
  output logic [qrrs_pkg::RW-1:0]         out_root
);
  logic [qrrs_pkg::DW-1:0] rem  [0:qrrs_pkg::RW-1];
  logic [qrrs_pkg::RW-1:0] root [0:qrrs_pkg::RW-1];
  qrrs_pkg::side_t         side [0:qrrs_pkg::RW-1];
  logic                    vld  [0:qrrs_pkg::RW-1];

  for (genvar i = 0; i < qrrs_pkg::RW; i++) begin : g_stage
    localparam int K = qrrs_pkg::RW - 1 - i;
    logic [qrrs_pkg::DW-1:0] rem_in;
    logic [qrrs_pkg::RW-1:0] root_in;
    qrrs_pkg::side_t         side_in;
    logic                    vld_in;
    logic [qrrs_pkg::DW-1:0] trial;
    logic                    take;

    if (i == 0) begin : g_first
      assign rem_in  = in_d;
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem[i-1];
      assign root_in = root[i-1];
      assign side_in = side[i-1];
      assign vld_in  = vld[i-1];
    end

    // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    assign trial = (qrrs_pkg::DW'(root_in) << (K + 1)) | (qrrs_pkg::DW'(1) << (2 * K));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= take ? rem_in - trial : rem_in;
        root[i] <= root_in | (take ? (qrrs_pkg::RW'(1) << K) : '0);
        side[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld[qrrs_pkg::RW-1];
  assign out_side = side[qrrs_pkg::RW-1];
  assign out_root = root[qrrs_pkg::RW-1];
endmodule
`default_nettype wire

// ----- design/qrrs_div.sv -----
// qrrs_div: unsigned restoring divider, one quotient bit per stage.
// Depends on qrrs_pkg.
`default_nettype none
module qrrs_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire qrrs_pkg::tag_t          in_tag,
  input  wire logic [qrrs_pkg::NW-1:0] in_n,
  input  wire logic [qrrs_pkg::MW-1:0] in_dm,
  output logic                         out_vld,
  output qrrs_pkg::tag_t               out_tag,
  output logic [qrrs_pkg::NW-1:0]      out_q
);
  logic [qrrs_pkg::MW-1:0] rr  [0:qrrs_pkg::NW-1];
  logic [qrrs_pkg::NW-1:0] q   [0:qrrs_pkg::NW-1];
  logic [qrrs_pkg::NW-1:0] n   [0:qrrs_pkg::NW-1];
  logic [qrrs_pkg::MW-1:0] dm  [0:qrrs_pkg::NW-1];
  qrrs_pkg::tag_t          tag [0:qrrs_pkg::NW-1];
  logic                    vld [0:qrrs_pkg::NW-1];

  for (genvar i = 0; i < qrrs_pkg::NW; i++) begin : g_stage
    localparam int K = qrrs_pkg::NW - 1 - i;
    logic [qrrs_pkg::MW-1:0] rr_in;
    logic [qrrs_pkg::NW-1:0] q_in;
    logic [qrrs_pkg::NW-1:0] n_in;
    logic [qrrs_pkg::MW-1:0] dm_in;
    qrrs_pkg::tag_t          tag_in;
    logic                    vld_in;
    logic [qrrs_pkg::MW:0]   r_sh;
    logic                    ge;

    if (i == 0) begin : g_first
      assign rr_in  = '0;
      assign q_in   = '0;
      assign n_in   = in_n;
      assign dm_in  = in_dm;
      assign tag_in = in_tag;
      assign vld_in = in_vld;
    end else begin : g_next
      assign rr_in  = rr[i-1];
      assign q_in   = q[i-1];
      assign n_in   = n[i-1];
      assign dm_in  = dm[i-1];
      assign tag_in = tag[i-1];
      assign vld_in = vld[i-1];
    end

    // bring down the next dividend bit, subtract if it fits
    assign r_sh = {rr_in, n_in[K]};
    assign ge   = (r_sh >= {1'b0, dm_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[i]  <= ge ? qrrs_pkg::MW'(r_sh - {1'b0, dm_in}) : r_sh[qrrs_pkg::MW-1:0];
        q[i]   <= q_in | (ge ? (qrrs_pkg::NW'(1) << K) : '0);
        n[i]   <= n_in;
        dm[i]  <= dm_in;
        tag[i] <= tag_in;
      end
    end
  end

  assign out_vld = vld[qrrs_pkg::NW-1];
  assign out_tag = tag[qrrs_pkg::NW-1];
  assign out_q   = q[qrrs_pkg::NW-1];
endmodule
`default_nettype wire

// ----- design/quadratic_real_root_solver.sv -----
// quadratic_real_root_solver: top level, real roots of a*x^2+b*x+c in Q16.16.
// Depends on qrrs_pkg, qrrs_disc, qrrs_sqrt, qrrs_div.
//
//   channel  signals                                   dir  request
//   in       in_valid in_ready coef_a coef_b coef_c    in   one coefficient set
//   out      out_valid out_ready root_status root_plus
//            root_minus saturated                      out  one root result
//
// One request enters per cycle while the pipe is not held; it passes through the
// products and discriminant, the bit-per-stage square root, the numerator
// register, the bit-per-stage dividers and the output register.
// rst (synchronous) clears every valid bit. All stages share one advance
// enable: when the output register is full and not taken, the whole pipe holds.
`default_nettype none
module quadratic_real_root_solver (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [qrrs_pkg::QW-1:0] coef_a,
  input  wire logic signed [qrrs_pkg::QW-1:0] coef_b,
  input  wire logic signed [qrrs_pkg::QW-1:0] coef_c,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output qrrs_pkg::status_t                  root_status,
  output logic signed [qrrs_pkg::QW-1:0]     root_plus,
  output logic signed [qrrs_pkg::QW-1:0]     root_minus,
  output logic                               saturated
);
  logic                       en;
  logic                       d_vld;
  qrrs_pkg::side_t            d_side;
  logic [qrrs_pkg::DW-1:0]    d_val;
  logic                       s_vld;
  qrrs_pkg::side_t            s_side;
  logic [qrrs_pkg::RW-1:0]    s_root;
  logic signed [qrrs_pkg::NUMW-1:0] bx;
  logic signed [qrrs_pkg::NUMW-1:0] sx;
  logic signed [qrrs_pkg::NUMW-1:0] np;
  logic signed [qrrs_pkg::NUMW-1:0] nm;
  logic [qrrs_pkg::NUMW-1:0]  np_mag;
  logic [qrrs_pkg::NUMW-1:0]  nm_mag;
  logic [qrrs_pkg::MW-1:0]    a_mag;
  logic                       n_vld;
  qrrs_pkg::tag_t             tag_p;
  qrrs_pkg::tag_t             tag_m;
  logic [qrrs_pkg::NW-1:0]    n_p;
  logic [qrrs_pkg::NW-1:0]    n_m;
  logic [qrrs_pkg::MW-1:0]    dm;
  logic                       p_vld;
  logic                       m_vld;
  qrrs_pkg::tag_t             p_tag;
  qrrs_pkg::tag_t             m_tag;
  logic [qrrs_pkg::NW-1:0]    q_p;
  logic [qrrs_pkg::NW-1:0]    q_m;
  logic [qrrs_pkg::QW-1:0]    rp_val;
  logic [qrrs_pkg::QW-1:0]    rm_val;
  logic                       rp_sat;
  logic                       rm_sat;
  logic                       has_root;

  // whole pipe advances unless a finished result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  qrrs_disc u_disc (
    .clk, .rst, .en,
    .in_vld   (in_valid),
    .a        (coef_a),
    .b        (coef_b),
    .c        (coef_c),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_d    (d_val)
  );

  qrrs_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_vld   (d_vld),
    .in_side  (d_side),
    .in_d     (d_val),
    .out_vld  (s_vld),
    .out_side (s_side),
    .out_root (s_root)
  );

  // numerators -b +/- s, split into sign and magnitude
  assign bx     = qrrs_pkg::NUMW'(s_side.b);
  assign sx     = $signed({2'b00, s_root});
  assign np     = sx - bx;
  assign nm     = -bx - sx;
  assign np_mag = np[qrrs_pkg::NUMW-1] ? qrrs_pkg::NUMW'(-np) : np;
  assign nm_mag = nm[qrrs_pkg::NUMW-1] ? qrrs_pkg::NUMW'(-nm) : nm;
  assign a_mag  = s_side.a[qrrs_pkg::QW-1] ? qrrs_pkg::MW'(-qrrs_pkg::MW'(s_side.a))
                                          : qrrs_pkg::MW'(s_side.a);

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (en) begin
      n_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p         <= {np_mag[qrrs_pkg::NW-qrrs_pkg::FRAC-1:0], {qrrs_pkg::FRAC{1'b0}}};
      n_m         <= {nm_mag[qrrs_pkg::NW-qrrs_pkg::FRAC-1:0], {qrrs_pkg::FRAC{1'b0}}};
      dm          <= {a_mag[qrrs_pkg::MW-2:0], 1'b0};
      tag_p.st    <= s_side.st;
      tag_p.q_neg <= np[qrrs_pkg::NUMW-1] ^ s_side.a[qrrs_pkg::QW-1];
      tag_m.st    <= s_side.st;
      tag_m.q_neg <= nm[qrrs_pkg::NUMW-1] ^ s_side.a[qrrs_pkg::QW-1];
    end
  end

  qrrs_div u_div_p (
    .clk, .rst, .en,
    .in_vld  (n_vld),
    .in_tag  (tag_p),
    .in_n    (n_p),
    .in_dm   (dm),
    .out_vld (p_vld),
    .out_tag (p_tag),
    .out_q   (q_p)
  );

  qrrs_div u_div_m (
    .clk, .rst, .en,
    .in_vld  (n_vld),
    .in_tag  (tag_m),
    .in_n    (n_m),
    .in_dm   (dm),
    .out_vld (m_vld),
    .out_tag (m_tag),
    .out_q   (q_m)
  );

  // apply sign and clamp to the Q16.16 range
  always_comb begin
    rp_sat = 1'b0;
    rm_sat = 1'b0;
    if (p_tag.q_neg) begin
      if (q_p > qrrs_pkg::NW'(64'h8000_0000)) begin
        rp_sat = 1'b1;
        rp_val = 32'h8000_0000;
      end else begin
        rp_val = -q_p[qrrs_pkg::QW-1:0];
      end
    end else begin
      if (q_p > qrrs_pkg::NW'(64'h7fff_ffff)) begin
        rp_sat = 1'b1;
        rp_val = 32'h7fff_ffff;
      end else begin
        rp_val = q_p[qrrs_pkg::QW-1:0];
      end
    end
    if (m_tag.q_neg) begin
      if (q_m > qrrs_pkg::NW'(64'h8000_0000)) begin
        rm_sat = 1'b1;
        rm_val = 32'h8000_0000;
      end else begin
        rm_val = -q_m[qrrs_pkg::QW-1:0];
      end
    end else begin
      if (q_m > qrrs_pkg::NW'(64'h7fff_ffff)) begin
        rm_sat = 1'b1;
        rm_val = 32'h7fff_ffff;
      end else begin
        rm_val = q_m[qrrs_pkg::QW-1:0];
      end
    end
  end

  assign has_root = (p_tag.st == qrrs_pkg::ST_ONE) || (p_tag.st == qrrs_pkg::ST_TWO);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p_vld && m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_status <= p_tag.st;
      root_plus   <= has_root ? $signed(rp_val) : '0;
      root_minus  <= has_root ? $signed(rm_val) : '0;
      saturated   <= has_root && (rp_sat || rm_sat);
    end
  end

`ifndef ASSERT_OFF
  a_ready_rule : assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  a_no_root_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_status == qrrs_pkg::ST_NONE || root_status == qrrs_pkg::ST_AZERO)
      |-> (root_plus == '0) && (root_minus == '0) && !saturated)
    else $error("result fields not cleared without a real root");

  a_one_root_equal : assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_status == qrrs_pkg::ST_ONE) |-> root_plus == root_minus)
    else $error("double root gives two different values");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_plus) && $stable(root_status))
    else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// tb: self-checking testbench for quadratic_real_root_solver.
// Depends on qrrs_pkg and the solver RTL; predicts each root result and compares.
`default_nettype none
module tb;
  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] coef_a, coef_b, coef_c;
  logic out_valid;
  logic out_ready;
  qrrs_pkg::status_t root_status;
  logic signed [31:0] root_plus, root_minus;
  logic saturated;

  typedef struct {
    qrrs_pkg::status_t st;
    logic [31:0] rp;
    logic [31:0] rm;
    logic sat;
  } roots_t;

  roots_t pending_roots[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  bit done = 0;

  quadratic_real_root_solver uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .root_status(root_status), .root_plus(root_plus),
    .root_minus(root_minus), .saturated(saturated)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // floor square root of a 68-bit discriminant, one bit at a time
  function automatic logic [33:0] isqrt68(logic [67:0] d);
    logic [33:0] r;
    logic [33:0] t;
    r = '0;
    for (int k = 33; k >= 0; k--) begin
      t = r | (34'd1 << k);
      if ({68'd0, t} * {68'd0, t} <= {68'd0, d}) r = t;
    end
    return r;
  endfunction

  // Q16.16 quotient truncated toward zero, clamped to 32 bits
  function automatic logic [31:0] qdiv_sat(logic signed [63:0] num,
                                           logic signed [63:0] den,
                                           inout logic sat);
    logic signed [63:0] q;
    q = (num <<< 16) / den;
    if (q > 64'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] a,
                                         logic signed [31:0] b,
                                         logic signed [31:0] c);
    roots_t r;
    logic signed [69:0] disc;
    logic [33:0] s;
    logic sat;
    r.st = qrrs_pkg::ST_NONE; r.rp = '0; r.rm = '0; r.sat = 0;
    sat = 0;
    if (a == 0) begin
      r.st = qrrs_pkg::ST_AZERO;
      return r;
    end
    disc = 70'(b) * 70'(b) - 70'sd4 * 70'(a) * 70'(c);
    if (disc < 0) return r;
    s = isqrt68(disc[67:0]);
    r.st = (disc == 0) ? qrrs_pkg::ST_ONE : qrrs_pkg::ST_TWO;
    r.rp = qdiv_sat(-64'(b) + 64'(s), 64'sd2 * 64'(a), sat);
    r.rm = qdiv_sat(-64'(b) - 64'(s), 64'sd2 * 64'(a), sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // send one coefficient request, idling at random beforehand
  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    coef_a <= a; coef_b <= b; coef_c <= c;
    pending_roots.push_back(solve_roots(a, b, c));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // random receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= calm || ($urandom_range(99) >= 12);
  end

  // check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      roots_t w;
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result", root_plus, '0);
      end else begin
        w = pending_roots.pop_front();
        if (root_status !== w.st) report_mismatch("root_status", root_status, w.st);
        if (root_plus !== w.rp) report_mismatch("root_plus", root_plus, w.rp);
        if (root_minus !== w.rm) report_mismatch("root_minus", root_minus, w.rm);
        if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst || done)
      idle_cycles <= 0;
    else if (idle_cycles >= 20000) begin
      $display("FAIL quadratic_real_root_solver");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 * 65536 * 16)) - 65536 * 16);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      3: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      default: return 32'($signed($urandom_range(2 * 65536 * 200)) - 65536 * 200);
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] ext[5] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 32'h1};
    foreach (ext[i]) send_coefs(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
    send_coefs(32'h80000000, 32'h80000000, 32'h80000000);
    send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_coefs(32'h1, 32'h80000000, 32'h80000000);
  endtask

  task automatic test_special_cases();
    send_coefs(32'h0, 32'h00010000, 32'h00020000);         // a is zero
    send_coefs(32'h00010000, 32'h0, 32'h00010000);         // no real roots
    send_coefs(32'h00010000, 32'h00020000, 32'h00010000);  // double root at -1
    send_coefs(32'h00010000, 32'h0, 32'hffff0000);         // two roots +/-1
    send_coefs(32'h00010000, 32'h0, 32'hffffffff);         // tiny positive disc
    send_coefs(32'hfffe0000, 32'h00030000, 32'h00050000);  // negative a
    send_coefs(32'h00000001, 32'h00640000, 32'h00000001);  // saturating roots
    send_coefs(32'h00000001, 32'h0, 32'h0);                // zero product
  endtask

  task automatic test_random();
    logic [31:0] a, b, c, m, k;
    for (int n = 0; n < 1930; n++) begin
      calm = (n >= 800 && n < 1000);
      a = rand_coef(); b = rand_coef(); c = rand_coef();
      if ($urandom_range(9) == 0) a = 0;
      // a = k<<16, b = -512*k*m, c = k*m*m gives b*b == 4*a*c exactly
      if ($urandom_range(7) == 0) begin
        m = 32'($signed($urandom_range(400)) - 200);
        k = 32'($urandom_range(3) + 1);
        a = k << 16;
        b = 32'(-512 * $signed(k) * $signed(m));
        c = 32'($signed(k) * $signed(m) * $signed(m));
      end
      send_coefs(a, b, c);
    end
    calm = 0;
  endtask

  initial begin
    int guard;
    rst = 1;
    in_valid = 0;
    coef_a = '0; coef_b = '0; coef_c = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random();
    in_valid <= 0;
    guard = 0;
    while (pending_roots.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    done = 1;
    if (errors == 0 && pending_roots.size() == 0)
      $display("PASS quadratic_real_root_solver");
    else
      $display("FAIL quadratic_real_root_solver");
    $finish;
  end
endmodule
`default_nettype wire
